>>> sv/espe_pkg.sv
// Shared types and constants for the encoder speed and position estimator.
// Used by every module of the block but espe_div; no dependencies.
package espe_pkg;

    // Field widths
    localparam int RAW_W      = 12;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int THR_W      = 12;
    localparam int SCALE_W    = 20;
    localparam int SPEED_W    = 32;
    localparam int REV_W      = 32;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // Default counts per mechanical revolution
    localparam int DEF_COUNTS_PER_REV = 4096;

    // Register reset values
    localparam logic [THR_W-1:0]   THR_RESET   = 12'd3000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd100531;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 1'b1;

    // Input transaction
    typedef struct packed {
        logic [RAW_W-1:0]  raw_count;
        logic [TIME_W-1:0] time_ms;
    } espe_in_t;

    // Output transaction
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [REV_W-1:0]   revolutions;
        logic [COUNT_W-1:0]        angle_count;
    } espe_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic calc;
        logic mul;
        logic div_start;
        logic load_out;
    } espe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic elapsed_zero;
        logic div_busy;
    } espe_status_t;

endpackage

>>> sv/espe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module espe_div #(
    parameter int N_W = 34,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [D_W:0] shifted;
    logic [D_W:0] diff;

    // Trial subtraction of the divisor from the shifted remainder
    assign shifted = {rem_reg, q_reg[N_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control: bit counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(N_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Data: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[D_W])
            begin
                rem_reg <= diff[D_W-1:0];
                q_reg   <= {q_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[D_W-1:0];
                q_reg   <= {q_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

>>> sv/espe_datapath.sv
// Datapath: sample capture, wrap correction, scale multiply, signed divide
// and saturation, plus the tracking state. Uses espe_pkg and espe_div.
module espe_datapath
    import espe_pkg::*;
#(
    parameter int COUNTS_PER_REV = DEF_COUNTS_PER_REV
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  espe_in_t              in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  espe_cmd_t             cmd,
    output espe_status_t          status,
    output espe_out_t             out_data
);

    // Delta must hold a count difference plus or minus one revolution
    localparam int DELTA_W = $clog2(COUNTS_PER_REV + (1 << COUNT_W)) + 1;
    localparam int PROD_W  = DELTA_W + SCALE_W + 1;
    localparam int MAG_W   = DELTA_W + SCALE_W - 1;
    localparam logic signed [DELTA_W-1:0] CPR_D = DELTA_W'(COUNTS_PER_REV);
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(33'h0_8000_0000);

    // Configuration
    logic [THR_W-1:0]   thr_reg;
    logic [SCALE_W-1:0] scale_reg;

    // Captured sample
    logic [RAW_W-1:0]  raw_reg;
    logic [TIME_W-1:0] now_reg;

    // Tracking state
    logic [COUNT_W-1:0]      prev_count_reg;
    logic [TIME_W-1:0]       prev_time_reg;
    logic [REV_W-1:0]        rev_reg;
    logic signed [SPEED_W-1:0] held_reg;

    // Work registers
    logic [COUNT_W-1:0]        count_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [TIME_W-1:0]  elapsed_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    espe_out_t                 out_reg;

    logic [COUNT_W-1:0]        count_c;
    logic signed [DELTA_W-1:0] delta0;
    logic signed [DELTA_W-1:0] delta1;
    logic signed [DELTA_W-1:0] delta2;
    logic signed [DELTA_W-1:0] thr_d;
    logic [REV_W-1:0]          rev1;
    logic [REV_W-1:0]          rev2;
    logic signed [PROD_W-1:0]  prod_neg;
    logic [MAG_W-1:0]          prod_abs;
    logic [TIME_W-1:0]         elapsed_abs;
    logic [MAG_W-1:0]          quot;
    logic signed [SPEED_W-1:0] speed_sat;
    logic signed [SPEED_W-1:0] speed_next;
    logic                      div_busy;

    // Angle count and wrap-corrected delta
    always_comb
    begin
        count_c = COUNT_W'(CPR_D - DELTA_W'(raw_reg));
        thr_d   = DELTA_W'(thr_reg);
        delta0  = DELTA_W'(count_c) - DELTA_W'(prev_count_reg);
        delta1  = delta0;
        rev1    = rev_reg;
        if (delta0 >= thr_d)
        begin
            delta1 = delta0 - CPR_D;
            rev1   = rev_reg - 1'b1;
        end
        delta2 = delta1;
        rev2   = rev1;
        if (delta1 <= -thr_d)
        begin
            delta2 = delta1 + CPR_D;
            rev2   = rev1 + 1'b1;
        end
    end

    // Magnitudes for the unsigned divider
    assign prod_neg    = -prod_reg;
    assign prod_abs    = prod_reg[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_reg[MAG_W-1:0];
    assign elapsed_abs = elapsed_reg[TIME_W-1] ? TIME_W'(-elapsed_reg) : TIME_W'(elapsed_reg);

    espe_div #(
        .N_W (MAG_W),
        .D_W (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_abs),
        .divisor  (elapsed_abs),
        .busy     (div_busy),
        .quotient (quot)
    );

    // Sign restore and saturation of the quotient
    always_comb
    begin
        if (!neg_reg)
        begin
            speed_sat = (quot > POS_LIMIT) ? 32'sh7FFF_FFFF : SPEED_W'(quot);
        end
        else
        begin
            speed_sat = (quot > NEG_LIMIT) ? 32'sh8000_0000 : SPEED_W'(-quot);
        end
        speed_next = (elapsed_reg == '0) ? held_reg : speed_sat;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WRAP_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                CFG_SPEED_SCALE:    scale_reg <= cfg_data[SCALE_W-1:0];
                default:            thr_reg   <= thr_reg;
            endcase
        end
    end

    // Tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            rev_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                prev_count_reg <= count_c;
                prev_time_reg  <= now_reg;
                rev_reg        <= rev2;
            end
            if (cmd.load_out)
            begin
                held_reg <= speed_next;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg <= in_data.raw_count;
            now_reg <= in_data.time_ms;
        end
        if (cmd.calc)
        begin
            count_reg   <= count_c;
            delta_reg   <= delta2;
            elapsed_reg <= now_reg - prev_time_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= delta_reg * $signed({1'b0, scale_reg});
        end
        if (cmd.div_start)
        begin
            neg_reg <= prod_reg[PROD_W-1] ^ elapsed_reg[TIME_W-1];
        end
        if (cmd.load_out)
        begin
            out_reg.speed       <= speed_next;
            out_reg.revolutions <= rev_reg;
            out_reg.angle_count <= count_reg;
        end
    end

    assign status.elapsed_zero = (elapsed_reg == '0);
    assign status.div_busy     = div_busy;
    assign out_data            = out_reg;

endmodule

>>> sv/espe_ctrl.sv
// Controller state machine: sequences one sample through the datapath and
// owns the output valid flag. Uses espe_pkg.
module espe_ctrl
    import espe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  espe_status_t status,
    output espe_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Commands decoded from state
    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == ST_IDLE) && in_valid;
        cmd.calc      = (state_reg == ST_CALC);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_START) && !status.elapsed_zero;
        cmd.load_out  = (state_reg == ST_FINISH) && out_free;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // set when a result is loaded, cleared on its transaction
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:  state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_START;
                ST_START: state_reg <= status.elapsed_zero ? ST_FINISH : ST_DIV;
                ST_DIV:
                begin
                    if (!status.div_busy)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> sv/encoder_speed_position_estimator.sv
// Encoder speed and position estimator, top level.
// Uses espe_pkg, espe_ctrl, espe_datapath (and espe_div below it).
//
// Input channel (in_valid/in_ready/in_data) takes one sample per transaction:
// the raw quadrature timer count and a millisecond timestamp. The output
// channel (out_valid/out_ready/out_data) returns one result per sample:
// saturated Q16.16 speed, revolution counter and angle count.
// cfg_we/cfg_index/cfg_data write wrap_threshold (index 0) and speed_scale
// (index 1) at any edge with cfg_we high; write only while idle.
//
// From input acceptance to out_valid a sample passes the states CALC, MUL,
// START, DIV and FINISH. In DIV the restoring divider retires one quotient
// bit per cycle, MAG_W bits in all (34 with the default 4096 counts per rev).
// A sample with no elapsed time skips DIV. One sample is in work at a time:
// the next is accepted only once the block is back in idle.
// A result waits in the output register while the receiver stalls; the next
// sample is still accepted and processed, and it waits before its final
// step until the register is free.
// Reset clears the tracking state to zero and loads the register defaults.
module encoder_speed_position_estimator
    import espe_pkg::*;
#(
    parameter int COUNTS_PER_REV = DEF_COUNTS_PER_REV
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  espe_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output espe_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    espe_cmd_t    cmd;
    espe_status_t status;

    espe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    espe_datapath #(
        .COUNTS_PER_REV (COUNTS_PER_REV)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

>>> sv/espe_checker.sv
// Port-level checks for the encoder speed and position estimator.
// Uses espe_pkg; bound to the top level at the end of this file.
module espe_checker
    import espe_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input espe_out_t out_data
);

    // Block goes busy after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready still high after input transaction");

    // A new result only appears at the end of a sample's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while block was idle");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

endmodule

bind encoder_speed_position_estimator espe_checker u_espe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for encoder_speed_position_estimator.
// Depends on espe_pkg and the block's RTL; a built-in motion predictor or a hand-typed row checks each result.
module tb;
    import espe_pkg::*;

    localparam int     CPR       = DEF_COUNTS_PER_REV;
    localparam int     PHASES    = 6;
    localparam int     PER_PHASE = 180;
    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    espe_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    espe_out_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    encoder_speed_position_estimator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed stimulus row: register setting, sample, optional hand-typed result
    typedef struct {
        logic [THR_W-1:0]   thr;
        logic [SCALE_W-1:0] scale;
        espe_in_t           smp;
        bit                 typed;
        espe_out_t          want;
    } sample_row_t;

    sample_row_t sample_table[$];
    espe_out_t   motion_due[$];

    // Predictor copy of registers and tracking state
    logic [THR_W-1:0]   wrap_thr;
    logic [SCALE_W-1:0] scale_q16;
    logic [COUNT_W-1:0] prev_angle;
    logic [TIME_W-1:0]  prev_stamp;
    logic [REV_W-1:0]   rev_count;
    logic [SPEED_W-1:0] speed_hold;

    // Stimulus walk state and run statistics
    logic [RAW_W-1:0]  walk_raw;
    logic [TIME_W-1:0] walk_time;
    bit                steady = 1'b0;
    int                mismatches = 0;
    int                n_sent = 0;
    int                n_checked = 0;
    int                n_settings = 0;
    int                n_wraps = 0;
    int                n_sat = 0;
    int                n_hold = 0;
    int                stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Expected result of one sample; advances the predictor state
    function automatic espe_out_t estimate_motion(espe_in_t smp);
        logic [COUNT_W-1:0] cnt;
        longint             diff;
        longint             quo;
        int                 elapsed;
        espe_out_t          res;
        cnt     = COUNT_W'(CPR - int'(smp.raw_count));
        diff    = longint'(cnt) - longint'(prev_angle);
        elapsed = int'(smp.time_ms - prev_stamp);
        // wrap correction, two independent tests
        if (diff >= longint'(wrap_thr))
        begin
            diff      = diff - CPR;
            rev_count = rev_count - 1;
            n_wraps++;
        end
        if (diff <= -longint'(wrap_thr))
        begin
            diff      = diff + CPR;
            rev_count = rev_count + 1;
            n_wraps++;
        end
        // speed, held when no time has passed
        if (elapsed != 0)
        begin
            quo = (diff * longint'(scale_q16)) / longint'(elapsed);
            if (quo > SPEED_MAX || quo < SPEED_MIN)
                n_sat++;
            if (quo > SPEED_MAX)
                quo = SPEED_MAX;
            else if (quo < SPEED_MIN)
                quo = SPEED_MIN;
            speed_hold = SPEED_W'(quo);
        end
        else
            n_hold++;
        prev_angle      = cnt;
        prev_stamp      = smp.time_ms;
        res.speed       = speed_hold;
        res.revolutions = rev_count;
        res.angle_count = cnt;
        return res;
    endfunction

    task automatic add_row(input int thr, input int scale, input int raw, input logic [31:0] tms,
                           input bit typed, input int spd, input int rev, input int ang);
        sample_row_t row;
        row.thr               = THR_W'(thr);
        row.scale             = SCALE_W'(scale);
        row.smp.raw_count     = RAW_W'(raw);
        row.smp.time_ms       = tms;
        row.typed             = typed;
        row.want.speed        = spd;
        row.want.revolutions  = rev;
        row.want.angle_count  = COUNT_W'(ang);
        sample_table.push_back(row);
    endtask

    // Present one sample, wait for the transaction, record its expected result
    task automatic send_sample(input espe_in_t smp, input bit typed, input espe_out_t want);
        int        gap;
        espe_out_t pred;
        gap = 0;
        if (!steady && $urandom_range(99) < 36)
            gap = $urandom_range(1, 45);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        pred = estimate_motion(smp);
        motion_due.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (motion_due.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers on consecutive edges; block is idle here
    task automatic program_regs(input logic [THR_W-1:0] thr, input logic [SCALE_W-1:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WRAP_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_SPEED_SCALE;
        cfg_data  <= CFG_DATA_W'(scale);
        @(posedge clk);
        cfg_we    <= 1'b0;
        wrap_thr  = thr;
        scale_q16 = scale;
        n_settings++;
    endtask

    // Next random sample: mostly smooth motion, some jumps, some noise
    function automatic espe_in_t next_sample();
        espe_in_t smp;
        int       sel;
        int       step;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            walk_raw  = RAW_W'($urandom);
            walk_time = $urandom;
        end
        else
        begin
            if (sel < 25)
                step = int'($urandom_range(4094)) - 2047;
            else
                step = int'($urandom_range(400)) - 200;
            walk_raw = walk_raw + RAW_W'(step);
            sel = $urandom_range(99);
            if (sel < 70)
                walk_time = walk_time + 1;
            else if (sel < 80)
                walk_time = walk_time;
            else if (sel < 92)
                walk_time = walk_time + $urandom_range(2, 1000);
            else
                walk_time = walk_time - $urandom_range(1, 5);
        end
        smp.raw_count = walk_raw;
        smp.time_ms   = walk_time;
        return smp;
    endfunction

    // Result checker and receiver back-pressure
    always @(posedge clk)
    begin : result_check
        espe_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (motion_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with nothing expected: speed %0d rev %0d angle %0d",
                                 out_data.speed, out_data.revolutions, out_data.angle_count);
                end
                else
                begin
                    want = motion_due.pop_front();
                    n_checked++;
                    if (out_data.speed !== want.speed
                        || out_data.revolutions !== want.revolutions
                        || out_data.angle_count !== want.angle_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d: speed %0d/%0d rev %0d/%0d angle %0d/%0d",
                                     n_checked, want.speed, out_data.speed, want.revolutions,
                                     out_data.revolutions, want.angle_count,
                                     out_data.angle_count);
                    end
                end
            end
            // random stalls, with an occasional long one
            if (steady)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < 36)
            begin
                out_ready <= 1'b0;
                if ($urandom_range(99) < 8)
                    stall_left = $urandom_range(5, 90);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        sample_row_t        row;
        espe_in_t           smp;
        espe_out_t          none;
        logic [THR_W-1:0]   thr;
        logic [SCALE_W-1:0] scale;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_WRAP_THRESHOLD;
        cfg_data   = '0;
        none       = '0;
        wrap_thr   = THR_RESET;
        scale_q16  = SCALE_RESET;
        prev_angle = '0;
        prev_stamp = '0;
        rev_count  = '0;
        speed_hold = '0;
        walk_raw   = '0;
        walk_time  = 32'd100;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // thr, scale, raw, time, typed, speed, revolutions, angle
        // first sample against reset state: full count wraps back
        add_row(3000, 100531,    0, 32'h0000_0000, 1, 0,      -1, 4096);
        add_row(3000, 100531, 4095, 32'h0000_0000, 1, 0,       0, 1);
        add_row(3000, 100531, 4095, 32'h0000_0001, 1, 0,       0, 1);
        add_row(3000, 100531, 4094, 32'h0000_0002, 1, 100531,  0, 2);
        // no time passed: speed held
        add_row(3000, 100531, 4094, 32'h0000_0002, 1, 100531,  0, 2);
        // timestamp goes back: negative elapsed flips sign
        add_row(3000, 100531, 4095, 32'h0000_0001, 1, 100531,  0, 1);
        add_row(3000, 100531, 2048, 32'h0000_0003, 0, 0, 0, 0);
        add_row(3000, 100531,    0, 32'h0000_0004, 0, 0, 0, 0);
        add_row(3000, 100531, 4095, 32'h0000_0005, 0, 0, 0, 0);
        add_row(3000, 100531,    0, 32'h0000_0006, 0, 0, 0, 0);
        // largest positive elapsed, then timestamp wrap
        add_row(3000, 100531, 'h0AB, 32'h8000_0005, 0, 0, 0, 0);
        add_row(3000, 100531, 'hF54, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(3000, 100531, 'hF54, 32'h0000_0000, 0, 0, 0, 0);
        // largest scale: positive saturation, most negative elapsed
        add_row(3000, 1048575, 4095, 32'h0000_0002, 0, 0, 0, 0);
        add_row(3000, 1048575, 1097, 32'h0000_0003, 0, 0, 0, 0);
        add_row(3000, 1048575, 1097, 32'h8000_0003, 0, 0, 0, 0);
        // largest threshold: wraps only at the full span
        add_row(4095, 100531,    1, 32'h0000_0004, 0, 0, 0, 0);
        add_row(4095, 100531, 4095, 32'h0000_0005, 0, 0, 0, 0);
        add_row(4095, 100531,    0, 32'h0000_0006, 0, 0, 0, 0);
        add_row(4095, 100531, 4095, 32'h0000_0007, 0, 0, 0, 0);
        // threshold one, zero scale: both tests fire on one sample
        add_row(1, 0, 4095, 32'h0000_0008, 0, 0, 0, 0);
        add_row(1, 0, 4094, 32'h0000_0009, 0, 0, 0, 0);
        // threshold zero
        add_row(0, 100531, 4094, 32'h0000_000A, 0, 0, 0, 0);
        add_row(0, 100531,    0, 32'h0000_0009, 0, 0, 0, 0);
        add_row(0, 100531, 4095, 32'h0000_0009, 0, 0, 0, 0);

        foreach (sample_table[i])
        begin
            row = sample_table[i];
            if (row.thr !== wrap_thr || row.scale !== scale_q16)
            begin
                settle();
                program_regs(row.thr, row.scale);
            end
            send_sample(row.smp, row.typed, row.want);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    thr   = THR_RESET;
                    scale = SCALE_RESET;
                end
                2:
                begin
                    thr   = 12'd1;
                    scale = 20'hF_FFFF;
                end
                3:
                begin
                    thr   = 12'd4095;
                    scale = 20'd1;
                end
                4:
                begin
                    thr   = THR_W'($urandom_range(1, 300));
                    scale = SCALE_W'($urandom);
                end
                default:
                begin
                    thr   = THR_W'($urandom_range(1, 4095));
                    scale = SCALE_W'($urandom);
                end
            endcase
            settle();
            program_regs(thr, scale);
            for (int k = 0; k < PER_PHASE; k++)
            begin
                steady = (p == 1 && k < 150);
                smp = next_sample();
                send_sample(smp, 1'b0, none);
            end
            steady = 1'b0;
        end

        settle();
        repeat (60) @(posedge clk);

        $display("Run: %0d samples, %0d results checked, %0d register settings",
                 n_sent, n_checked, n_settings);
        $display("Seen: %0d wrap corrections, %0d saturated speeds, %0d held speeds",
                 n_wraps, n_sat, n_hold);
        if (mismatches == 0 && motion_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
